>>> sv/fbrc_pkg.sv
`timescale 1ns / 1ps
// Package for the failsafe brake ramp controller: command codes, register
// indexes, controller states, datapath command/status structs, constants.
package fbrc_pkg;

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdTrigger = 2'd1,
    CmdClear   = 2'd2,
    CmdQuery   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RegStopThr  = 3'd0,
    RegStart    = 3'd1,
    RegFinal    = 3'd2,
    RegDuration = 3'd3,
    RegPollMs   = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ClrOk      = 2'd0,
    ClrMoving  = 2'd1,
    ClrFault   = 2'd2
  } clr_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StMul,
    StDivInit,
    StDiv,
    StFin
  } ctrl_state_e;

  localparam logic [1:0]  CauseManual   = 2'd0;
  localparam logic [1:0]  CauseBusFault = 2'd2;
  localparam logic [7:0]  NeutralLevel  = 8'd128;

  localparam logic [15:0] RstStopThr    = 16'd300;
  localparam logic [7:0]  RstStart      = 8'd109;
  localparam logic [7:0]  RstFinal      = 8'd100;
  localparam logic [15:0] RstDuration   = 16'd10000;
  localparam logic [15:0] RstPollMs     = 16'd100;

  // drop numerator: 8b level span x 16b time, plus rounding addend
  localparam int ProdW   = 24;
  localparam int DivBits = ProdW + 1;
  localparam int CntW    = $clog2(DivBits);

  typedef struct packed {
    logic capture;
    logic exec;
    logic mul;
    logic div_init;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_ramp;
  } dp_stat_t;

endpackage

>>> sv/fbrc_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the brake ramp controller: item handshake, divider step
// count and output register valid. Uses fbrc_pkg.
module fbrc_ctrl import fbrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [CntW-1:0] DivLast = CntW'(DivBits - 1);

  ctrl_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_ramp ? StMul : StFin;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDivInit;
      end
      StDivInit: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) state_d = StFin;
      end
      StFin: begin
        // result register frees up this cycle or already is empty
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;

endmodule

>>> sv/fbrc_dp.sv
`timescale 1ns / 1ps
// Datapath of the brake ramp controller: config registers, latch state,
// item and result registers, ramp multiply and restoring divider. Uses fbrc_pkg.
module fbrc_dp import fbrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  cause_i,
  input  logic        bus_fault_i,
  input  logic [30:0] max_abs_speed_i,
  input  logic [7:0]  motor_id_i,
  input  logic signed [31:0] motor_speed_i,
  output logic        failsafe_on_o,
  output logic [1:0]  active_cause_o,
  output logic [1:0]  clear_status_o,
  output logic        send_brake_o,
  output logic [7:0]  target_id_o,
  output logic [7:0]  brake_level_o
);

  // configuration
  logic [15:0] stop_thr_q, dur_q, poll_ms_q;
  logic [7:0]  start_q, final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_thr_q <= RstStopThr;
      start_q    <= RstStart;
      final_q    <= RstFinal;
      dur_q      <= RstDuration;
      poll_ms_q  <= RstPollMs;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegStopThr:  stop_thr_q <= cfg_wdata_i;
        RegStart:    start_q    <= cfg_wdata_i[7:0];
        RegFinal:    final_q    <= cfg_wdata_i[7:0];
        RegDuration: dur_q      <= cfg_wdata_i;
        RegPollMs:   poll_ms_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // latch state
  logic        latched_q, latched_d;
  logic [1:0]  cause_q, cause_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] poll_q, poll_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= 1'b0;
      cause_q   <= CauseManual;
      elapsed_q <= '0;
      poll_q    <= '0;
    end else if (cmd_i.exec) begin
      latched_q <= latched_d;
      cause_q   <= cause_d;
      elapsed_q <= elapsed_d;
      poll_q    <= poll_d;
    end
  end

  // captured item
  cmd_e        icmd_q;
  logic [1:0]  icause_q;
  logic        ibf_q;
  logic [30:0] iabs_q;
  logic [7:0]  iid_q;
  logic [31:0] ispeed_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      icmd_q   <= cmd_e'(command_i);
      icause_q <= cause_i;
      ibf_q    <= bus_fault_i;
      iabs_q   <= max_abs_speed_i;
      iid_q    <= motor_id_i;
      ispeed_q <= motor_speed_i;
    end
  end

  logic [15:0] elapsed_inc, poll_inc, t_lim;
  logic [7:0]  fin_clamp, span;
  logic        poll_hit, forward, moving, need_ramp;
  clr_e        clr_d;
  logic        send_d;
  logic [7:0]  id_d, lvl_d;

  assign elapsed_inc = (latched_q && elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
  assign poll_inc    = (poll_q != 16'hFFFF) ? poll_q + 16'd1 : poll_q;
  assign poll_hit    = (poll_inc >= poll_ms_q);
  assign fin_clamp   = (final_q > start_q) ? start_q : final_q;
  assign span        = start_q - fin_clamp;
  assign t_lim       = (elapsed_q < dur_q) ? elapsed_q : dur_q;
  assign forward     = !ispeed_q[31] && (ispeed_q[30:0] > {15'd0, stop_thr_q});
  assign moving      = (iabs_q >= {15'd0, stop_thr_q});
  assign need_ramp   = (icmd_q == CmdQuery) && latched_q && forward && (dur_q != 16'd0);
  assign stat_o.need_ramp = need_ramp;

  always_comb begin
    latched_d = latched_q;
    cause_d   = cause_q;
    elapsed_d = elapsed_q;
    poll_d    = poll_q;
    clr_d     = ClrOk;
    send_d    = 1'b0;
    id_d      = '0;
    lvl_d     = NeutralLevel;
    unique case (icmd_q)
      CmdTick: begin
        elapsed_d = elapsed_inc;
        poll_d    = poll_inc;
        if (poll_hit) begin
          poll_d = '0;
          if (ibf_q && !latched_q) begin
            latched_d = 1'b1;
            cause_d   = CauseBusFault;
            elapsed_d = '0;
          end
        end
      end
      CmdTrigger: begin
        if (!latched_q) begin
          latched_d = 1'b1;
          cause_d   = icause_q;
          elapsed_d = '0;
        end
      end
      CmdClear: begin
        if (latched_q) begin
          if (moving) clr_d = ClrMoving;
          else if (cause_q == CauseBusFault && ibf_q) clr_d = ClrFault;
          else latched_d = 1'b0;
        end
      end
      CmdQuery: begin
        if (latched_q) begin
          send_d = 1'b1;
          id_d   = iid_q;
          // zero duration: ramp complete, final level
          if (forward) lvl_d = fin_clamp;
        end
      end
      default: ;
    endcase
  end

  // per-item result, held until the output register loads
  clr_e       clr_q;
  logic       send_q, use_ramp_q;
  logic [7:0] id_q, lvl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      clr_q      <= clr_d;
      send_q     <= send_d;
      id_q       <= id_d;
      lvl_q      <= lvl_d;
      use_ramp_q <= need_ramp;
    end
  end

  // drop = ceil(span * t / duration), one quotient bit per cycle
  logic [ProdW-1:0]   prod_q;
  logic [DivBits-1:0] quo_q;
  logic [15:0]        rem_q;
  logic [16:0]        trial;
  logic               fits;

  assign trial = {rem_q, quo_q[DivBits-1]};
  assign fits  = (trial >= {1'b0, dur_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= {{(ProdW-8){1'b0}}, span} * {{(ProdW-16){1'b0}}, t_lim};
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= {1'b0, prod_q} + {{(DivBits-16){1'b0}}, dur_q} - {{(DivBits-1){1'b0}}, 1'b1};
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? 16'(trial - {1'b0, dur_q}) : trial[15:0];
      quo_q <= {quo_q[DivBits-2:0], fits};
    end
  end

  // output register
  logic       on_q, send_oq;
  logic [1:0] acause_q, clr_oq;
  logic [7:0] tid_q, blevel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      on_q     <= latched_q;
      acause_q <= cause_q;
      clr_oq   <= clr_q;
      send_oq  <= send_q;
      tid_q    <= id_q;
      blevel_q <= use_ramp_q ? start_q - quo_q[7:0] : lvl_q;
    end
  end

  assign failsafe_on_o  = on_q;
  assign active_cause_o = acause_q;
  assign clear_status_o = clr_oq;
  assign send_brake_o   = send_oq;
  assign target_id_o    = tid_q;
  assign brake_level_o  = blevel_q;

endmodule

>>> sv/failsafe_brake_ramp_controller_core.sv
`timescale 1ns / 1ps
// Top level of the failsafe brake ramp controller: stream ports, config
// port, sequencer and datapath. Uses fbrc_pkg, fbrc_ctrl, fbrc_dp.
//
//  channel   | dir | beat
//  ----------+-----+---------------------------------------------------
//  s_axis    | in  | one command (tick, trigger, try clear, brake query)
//  m_axis    | out | one result beat per command beat
//  cfg       | in  | register write, no wait, no read-back
//
// Tick, trigger, try clear and a query without ramp go accept, exec, final
// step, result registered from the final step; a brake query that ramps
// runs exec, multiply, divider setup, then the 25-step restoring divider
// (one quotient bit per cycle), then the final step.
// Reset puts the latch idle and loads the default register values.
// A new beat is accepted while a finished result waits on m_axis; the
// block stalls in its final step only when a second result is ready.
module failsafe_brake_ramp_controller_core import fbrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] cause, [2] bus_fault, [33:3] max_abs_speed, [41:34] motor_id,
  // [73:42] motor_speed, [79:74] zero
  input  logic [79:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] failsafe_on, [2:1] active_cause, [4:3] clear_status,
  // [12:5] target_id, [20:13] brake_level, [23:21] zero
  output logic [23:0] m_axis_tdata_o,
  // [0] send_brake
  output logic        m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       on, send;
  logic [1:0] acause, clr;
  logic [7:0] tid, level;

  fbrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fbrc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (s_axis_tuser_i),
    .cause_i         (s_axis_tdata_i[1:0]),
    .bus_fault_i     (s_axis_tdata_i[2]),
    .max_abs_speed_i (s_axis_tdata_i[33:3]),
    .motor_id_i      (s_axis_tdata_i[41:34]),
    .motor_speed_i   (s_axis_tdata_i[73:42]),
    .failsafe_on_o   (on),
    .active_cause_o  (acause),
    .clear_status_o  (clr),
    .send_brake_o    (send),
    .target_id_o     (tid),
    .brake_level_o   (level)
  );

  assign m_axis_tdata_o = {3'd0, level, tid, clr, acause, on};
  assign m_axis_tuser_o = send;

endmodule

>>> sv/fbrc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the failsafe brake ramp controller, bound to the
// top level. Uses fbrc_pkg.
module fbrc_checker import fbrc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [79:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_addr_i,
  input logic [15:0] cfg_wdata_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // a brake command only goes out while failsafe is latched
  a_brake_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[0])
    else $error("brake command without failsafe");

  // no brake command: neutral level, no target
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[20:13] == NeutralLevel && m_axis_tdata_o[12:5] == 8'd0)
    else $error("non-brake result carries brake fields");

endmodule

bind failsafe_brake_ramp_controller_core fbrc_checker u_fbrc_checker (.*);

>>> tb/failsafe_brake_ramp_controller_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for failsafe_brake_ramp_controller_core: directed rows
// with typed results, then random beats under several register settings;
// untyped beats scored by an in-bench latch/poll/ramp model. Uses fbrc_pkg.
module failsafe_brake_ramp_controller_core_tb;
  import fbrc_pkg::*;

  localparam logic [1:0] CauseDropout = 2'd1;
  localparam logic [1:0] CauseOther   = 2'd3;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 400;

  typedef struct packed {
    logic       on;
    logic [1:0] cause;
    logic [1:0] status;
    logic       brake;
    logic [7:0] id;
    logic [7:0] level;
  } brake_result_t;

  typedef struct packed {
    cmd_e          cmd;
    logic [1:0]    cause;
    logic          bus;
    logic [30:0]   abs_spd;
    logic [7:0]    id;
    logic [31:0]   spd;
    logic          typed;
    brake_result_t want;
  } stim_row_t;

  localparam brake_result_t NoWant = '0;

  // reset register values throughout; want is typed where obvious
  localparam stim_row_t DirectedRows [21] = '{
    '{CmdQuery, CauseManual, 1'b0, 31'd0, 8'h55, 32'd1000, 1'b1,
      '{1'b0, CauseManual, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdClear, CauseManual, 1'b1, 31'h7FFF_FFFF, 8'h00, 32'd0, 1'b1,
      '{1'b0, CauseManual, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdTrigger, CauseOther, 1'b0, 31'd0, 8'h00, 32'd0, 1'b1,
      '{1'b1, CauseOther, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    // trigger while latched keeps the first cause
    '{CmdTrigger, CauseDropout, 1'b0, 31'd0, 8'h00, 32'd0, 1'b1,
      '{1'b1, CauseOther, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdQuery, CauseManual, 1'b0, 31'd0, 8'hFF, 32'h7FFF_FFFF, 1'b1,
      '{1'b1, CauseOther, ClrOk, 1'b1, 8'hFF, RstStart}},
    '{CmdQuery, CauseManual, 1'b0, 31'd0, 8'h00, 32'h8000_0000, 1'b1,
      '{1'b1, CauseOther, ClrOk, 1'b1, 8'h00, NeutralLevel}},
    '{CmdQuery, CauseManual, 1'b0, 31'd0, 8'hAA, 32'd300, 1'b1,
      '{1'b1, CauseOther, ClrOk, 1'b1, 8'hAA, NeutralLevel}},
    '{CmdQuery, CauseManual, 1'b0, 31'd0, 8'h01, 32'd301, 1'b1,
      '{1'b1, CauseOther, ClrOk, 1'b1, 8'h01, RstStart}},
    '{CmdTick, CauseManual, 1'b0, 31'd0, 8'h00, 32'd0, 1'b1,
      '{1'b1, CauseOther, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdQuery, CauseManual, 1'b0, 31'd0, 8'h02, 32'd301, 1'b0, NoWant},
    '{CmdQuery, CauseManual, 1'b0, 31'd0, 8'h03, 32'hFFFF_FFFF, 1'b1,
      '{1'b1, CauseOther, ClrOk, 1'b1, 8'h03, NeutralLevel}},
    '{CmdClear, CauseManual, 1'b0, 31'd300, 8'h00, 32'd0, 1'b1,
      '{1'b1, CauseOther, ClrMoving, 1'b0, 8'h00, NeutralLevel}},
    '{CmdClear, CauseManual, 1'b1, 31'd299, 8'h00, 32'd0, 1'b1,
      '{1'b0, CauseOther, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdClear, CauseManual, 1'b1, 31'h7FFF_FFFF, 8'h00, 32'd0, 1'b1,
      '{1'b0, CauseOther, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdQuery, CauseManual, 1'b0, 31'd0, 8'hFF, 32'h7FFF_FFFF, 1'b1,
      '{1'b0, CauseOther, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdTrigger, CauseBusFault, 1'b0, 31'd0, 8'h00, 32'd0, 1'b1,
      '{1'b1, CauseBusFault, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdTick, CauseManual, 1'b1, 31'd0, 8'h00, 32'd0, 1'b0, NoWant},
    '{CmdClear, CauseManual, 1'b1, 31'd0, 8'h00, 32'd0, 1'b1,
      '{1'b1, CauseBusFault, ClrFault, 1'b0, 8'h00, NeutralLevel}},
    '{CmdClear, CauseManual, 1'b0, 31'd299, 8'h00, 32'd0, 1'b1,
      '{1'b0, CauseBusFault, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdTrigger, CauseManual, 1'b0, 31'd0, 8'h00, 32'd0, 1'b1,
      '{1'b1, CauseManual, ClrOk, 1'b0, 8'h00, NeutralLevel}},
    '{CmdClear, CauseManual, 1'b1, 31'd0, 8'h00, 32'd0, 1'b1,
      '{1'b0, CauseManual, ClrOk, 1'b0, 8'h00, NeutralLevel}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;

  failsafe_brake_ramp_controller_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // model state and register copies
  logic        failsafe_latched;
  logic [1:0]  failsafe_cause;
  logic [15:0] ramp_ms;
  logic [15:0] poll_ticks;
  logic [15:0] cfg_stop_thr;
  logic [7:0]  cfg_start;
  logic [7:0]  cfg_final;
  logic [15:0] cfg_ramp_ms;
  logic [15:0] cfg_poll_ms;

  brake_result_t pending_results[$];
  int unsigned   err_count;
  int unsigned   results_seen;
  bit            quiet_run;
  brake_result_t mon_want;
  brake_result_t mon_got;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= 40)
      $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  function automatic int unsigned draw_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void latch_failsafe(input logic [1:0] why);
    if (!failsafe_latched) begin
      failsafe_latched = 1'b1;
      failsafe_cause   = why;
      ramp_ms          = '0;
    end
  endfunction

  function automatic logic [7:0] ramp_level_now();
    int unsigned s, f, t, drop;
    s = cfg_start;
    f = cfg_final;
    if (f > s) f = s;
    if (cfg_ramp_ms == 0) return 8'(f);
    t = (ramp_ms < cfg_ramp_ms) ? ramp_ms : cfg_ramp_ms;
    drop = ((s - f) * t + cfg_ramp_ms - 1) / cfg_ramp_ms;
    return 8'(s - drop);
  endfunction

  function automatic brake_result_t advance_failsafe(input stim_row_t r);
    brake_result_t res;
    res = '0;
    res.level = NeutralLevel;
    case (r.cmd)
      CmdTick: begin
        // ramp time moves first, so a poll latch starts the ramp at zero
        if (failsafe_latched && ramp_ms != 16'hFFFF) ramp_ms++;
        if (poll_ticks != 16'hFFFF) poll_ticks++;
        if (poll_ticks >= cfg_poll_ms) begin
          poll_ticks = '0;
          if (r.bus && !failsafe_latched) latch_failsafe(CauseBusFault);
        end
      end
      CmdTrigger: latch_failsafe(r.cause);
      CmdClear: begin
        if (failsafe_latched) begin
          if (32'(r.abs_spd) >= 32'(cfg_stop_thr)) res.status = ClrMoving;
          else if (failsafe_cause == CauseBusFault && r.bus) res.status = ClrFault;
          else failsafe_latched = 1'b0;
        end
      end
      default: begin
        if (failsafe_latched) begin
          res.brake = 1'b1;
          res.id    = r.id;
          if (!r.spd[31] && r.spd > 32'(cfg_stop_thr)) res.level = ramp_level_now();
        end
      end
    endcase
    res.on    = failsafe_latched;
    res.cause = failsafe_cause;
    return res;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t   r;
    int unsigned pick, span;
    r = '0;
    span = 32'(cfg_stop_thr) * 2 + 2;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.cmd = CmdTick;
    else if (pick < 50) r.cmd = CmdTrigger;
    else if (pick < 70) r.cmd = CmdClear;
    else r.cmd = CmdQuery;
    r.cause = 2'($urandom);
    r.bus   = 1'($urandom);
    r.id    = 8'($urandom);
    case ($urandom_range(0, 3))
      0: r.abs_spd = 31'($urandom);
      1: r.abs_spd = 31'(32'(cfg_stop_thr) + $urandom_range(0, 2) - 1);
      default: r.abs_spd = 31'($urandom_range(0, span));
    endcase
    case ($urandom_range(0, 3))
      0: r.spd = $urandom;
      1: r.spd = 32'(cfg_stop_thr) + $urandom_range(0, 2) - 1;
      2: r.spd = 32'd0 - 32'($urandom_range(1, 5000));
      default: r.spd = $urandom_range(0, span);
    endcase
    return r;
  endfunction

  task automatic idle_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
  endtask

  task automatic drive_row(input stim_row_t r);
    brake_result_t model_out;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.cmd;
    s_axis_tdata_i  <= {6'd0, r.spd, r.id, r.abs_spd, r.bus, r.cause};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    model_out = advance_failsafe(r);
    pending_results.push_back(r.typed ? r.want : model_out);
    if (!quiet_run) idle_sender(draw_gap());
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
  endtask

  task automatic load_settings(input logic [15:0] thr, input logic [7:0] st,
                               input logic [7:0] fin, input logic [15:0] dur,
                               input logic [15:0] poll);
    wait_drained();
    write_reg(RegStopThr, thr);
    write_reg(RegStart, {8'd0, st});
    write_reg(RegFinal, {8'd0, fin});
    write_reg(RegDuration, dur);
    write_reg(RegPollMs, poll);
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    cfg_stop_thr = thr;
    cfg_start    = st;
    cfg_final    = fin;
    cfg_ramp_ms  = dur;
    cfg_poll_ms  = poll;
  endtask

  task automatic random_phase(input int unsigned n);
    repeat (n) drive_row(random_row());
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      mon_got = '{m_axis_tdata_o[0], m_axis_tdata_o[2:1], m_axis_tdata_o[4:3],
                  m_axis_tuser_o, m_axis_tdata_o[12:5], m_axis_tdata_o[20:13]};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", results_seen, 0);
      end else begin
        mon_want = pending_results.pop_front();
        if (mon_got.on !== mon_want.on)
          report_mismatch("failsafe_on", mon_got.on, mon_want.on);
        if (mon_got.cause !== mon_want.cause)
          report_mismatch("active_cause", mon_got.cause, mon_want.cause);
        if (mon_got.status !== mon_want.status)
          report_mismatch("clear_status", mon_got.status, mon_want.status);
        if (mon_got.brake !== mon_want.brake)
          report_mismatch("send_brake", mon_got.brake, mon_want.brake);
        if (mon_got.id !== mon_want.id)
          report_mismatch("target_id", mon_got.id, mon_want.id);
        if (mon_got.level !== mon_want.level)
          report_mismatch("brake_level", mon_got.level, mon_want.level);
      end
    end
  end

  // result sink: random stalls plus one long hold-off to back up the block
  initial begin
    int unsigned stall_left;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (stall_left > 0 && !quiet_run) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = quiet_run ? 0 : draw_gap();
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("failsafe_brake_ramp_controller_core_tb: errors");
    $finish;
  end

  initial begin
    stim_row_t row;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CmdTick;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = RegStopThr;
    cfg_wdata_i     = '0;
    err_count       = 0;
    results_seen    = 0;
    quiet_run       = 1'b0;
    failsafe_latched = 1'b0;
    failsafe_cause   = CauseManual;
    ramp_ms          = '0;
    poll_ticks       = '0;
    cfg_stop_thr     = RstStopThr;
    cfg_start        = RstStart;
    cfg_final        = RstFinal;
    cfg_ramp_ms      = RstDuration;
    cfg_poll_ms      = RstPollMs;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) drive_row(DirectedRows[i]);

    // lowest threshold, one-tick ramp, poll every tick
    load_settings(16'd0, 8'd128, 8'd0, 16'd1, 16'd1);
    random_phase(250);
    load_settings(16'd50, 8'd128, 8'd0, 16'd40, 16'd3);
    random_phase(400);
    // final above start, longest ramp and poll
    load_settings(16'hFFFF, 8'd0, 8'd128, 16'hFFFF, 16'hFFFF);
    random_phase(200);
    // zero ramp length, zero poll interval, levels past neutral; no idling
    load_settings(16'd300, 8'd255, 8'd3, 16'd0, 16'd0);
    quiet_run = 1'b1;
    random_phase(300);
    quiet_run = 1'b0;
    load_settings(16'd1000, 8'd120, 8'd20, 16'd200, 16'd7);
    random_phase(350);

    // walk the ramp past its end, querying along the way
    load_settings(16'd300, 8'd128, 8'd0, 16'd100, 16'hFFFF);
    quiet_run = 1'b1;
    row = '0;
    row.cmd   = CmdTrigger;
    row.cause = CauseOther;
    drive_row(row);
    for (int i = 0; i < 120; i++) begin
      row = '0;
      row.bus = 1'($urandom);
      if (i % 8 == 0) begin
        row.cmd = CmdQuery;
        row.id  = 8'(i >> 3);
        row.spd = 32'h7FFF_FFFF;
        drive_row(row);
      end
      row.cmd = CmdTick;
      drive_row(row);
    end
    row.cmd = CmdQuery;
    row.id  = 8'hFF;
    drive_row(row);
    quiet_run = 1'b0;

    load_settings(16'($urandom_range(0, 2000)), 8'($urandom), 8'($urandom),
                  16'($urandom_range(1, 500)), 16'($urandom_range(1, 20)));
    random_phase(150);

    wait_drained();
    if (err_count == 0)
      $display("failsafe_brake_ramp_controller_core_tb: clean");
    else
      $display("failsafe_brake_ramp_controller_core_tb: errors");
    $finish;
  end

endmodule
